@@ hdl/slpw_pkg.sv @@
package slpw_pkg;

  localparam int RING_BYTES        = 128;
  localparam int RING_AW           = $clog2(RING_BYTES);
  localparam int COLUMNS_DEFAULT   = 48;
  localparam int BOARDS_DEFAULT    = 4;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_REFRESH = 2'd1;
  localparam logic [1:0] OP_BCAST   = 2'd2;

  localparam logic CFG_EVEN_SHIFT = 1'b0;
  localparam logic CFG_START_ADDR = 1'b1;

  localparam logic [11:0] PREFIX_CMD = 12'h280;
  localparam logic [11:0] CMD_MASK   = 12'hFFF;

  localparam logic [3:0] BITS_DATA   = 4'd8;
  localparam logic [3:0] BITS_PREFIX = 4'd10;
  localparam logic [3:0] BITS_CMD    = 4'd12;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  board;
    logic [6:0]  ring_address;
    logic [7:0]  byte_value;
    logic [6:0]  scroll_offset;
    logic [11:0] command_code;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  panel_select;
    logic [3:0]  bit_count;
    logic [11:0] serial_word;
    logic        release_select;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         board;
    logic [RING_AW-1:0] pos;
    logic [11:0]        data;
  } cmd_t;

endpackage

@@ hdl/scrolling_led_panel_writer_top.sv @@
// Each word is registered in s1 and then in out_r; a load only writes the ring.
// A refresh holds the ring sequencer for a prefix word and one word per column,
// one ring read per data word; a broadcast for one word per board.
// A 4-entry request queue lets input keep flowing while the sequencer works.
// Reset (rst_n low, synchronous) empties the queue and output stages and restores
// the registers; ring contents are not cleared and stay undefined until loaded.
module scrolling_led_panel_writer_top #(
  parameter int COLUMNS_PER_BOARD = slpw_pkg::COLUMNS_DEFAULT,
  parameter int BOARD_COUNT       = slpw_pkg::BOARDS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  slpw_pkg::in_req_t   in_req,
  output logic                out_empty,
  input  logic                out_pop,
  output slpw_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);

  logic [2:0]     even_shift_r;
  logic [6:0]     start_addr_r;
  logic           q_full, q_push, q_valid, q_pop;
  slpw_pkg::cmd_t q_din, q_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      even_shift_r <= 3'd2;
      start_addr_r <= 7'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        slpw_pkg::CFG_EVEN_SHIFT: even_shift_r <= cfg_data[2:0];
        slpw_pkg::CFG_START_ADDR: start_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  slpw_front #(
    .COLUMNS_PER_BOARD(COLUMNS_PER_BOARD),
    .BOARD_COUNT(BOARD_COUNT)
  ) u_front (
    .in_push(in_push),
    .in_req(in_req),
    .in_full(in_full),
    .q_full(q_full),
    .q_push(q_push),
    .q_cmd(q_din)
  );

  slpw_fifo u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .din(q_din),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .dout(q_dout)
  );

  slpw_back #(
    .COLUMNS_PER_BOARD(COLUMNS_PER_BOARD),
    .BOARD_COUNT(BOARD_COUNT)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_cmd(q_dout),
    .q_pop(q_pop),
    .even_shift(even_shift_r),
    .start_addr(start_addr_r),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_word(out_word)
  );

endmodule

@@ hdl/slpw_front.sv @@
module slpw_front #(
  parameter int COLUMNS_PER_BOARD = slpw_pkg::COLUMNS_DEFAULT,
  parameter int BOARD_COUNT       = slpw_pkg::BOARDS_DEFAULT
) (
  input  logic              in_push,
  input  slpw_pkg::in_req_t in_req,
  output logic              in_full,
  input  logic              q_full,
  output logic              q_push,
  output slpw_pkg::cmd_t    q_cmd
);

  logic        keep;
  logic [15:0] start_sum;

  always_comb begin
    start_sum = 16'(in_req.scroll_offset) + 16'(COLUMNS_PER_BOARD) * 16'(in_req.board);
    q_cmd.kind  = in_req.operation;
    q_cmd.board = in_req.board;
    q_cmd.pos   = start_sum[slpw_pkg::RING_AW-1:0];
    q_cmd.data  = in_req.command_code & slpw_pkg::CMD_MASK;
    keep        = 1'b0;
    case (in_req.operation)
      slpw_pkg::OP_LOAD: begin
        keep       = 1'b1;
        q_cmd.pos  = slpw_pkg::RING_AW'(in_req.ring_address);
        q_cmd.data = {4'd0, in_req.byte_value};
      end
      slpw_pkg::OP_REFRESH: begin
        keep = (3'(in_req.board) < 3'(BOARD_COUNT));
      end
      slpw_pkg::OP_BCAST: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && keep;

endmodule

@@ hdl/slpw_fifo.sv @@
module slpw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slpw_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output slpw_pkg::cmd_t dout
);

  localparam int PW = $clog2(slpw_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(slpw_pkg::QUEUE_DEPTH + 1);

  slpw_pkg::cmd_t slot_r [slpw_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == CW'(slpw_pkg::QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ hdl/slpw_back.sv @@
module slpw_back #(
  parameter int COLUMNS_PER_BOARD = slpw_pkg::COLUMNS_DEFAULT,
  parameter int BOARD_COUNT       = slpw_pkg::BOARDS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  slpw_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  input  logic [2:0]          even_shift,
  input  logic [6:0]          start_addr,
  output logic                out_empty,
  input  logic                out_pop,
  output slpw_pkg::out_word_t out_word
);

  localparam int CNT_W = ($clog2(COLUMNS_PER_BOARD) > 2) ? $clog2(COLUMNS_PER_BOARD) : 2;
  localparam int AW    = slpw_pkg::RING_AW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRE  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_BC   = 2'd3;

  logic [7:0] ring [slpw_pkg::RING_BYTES];

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [1:0]          board_r, board_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [11:0]         data_r, data_nxt;

  logic                s1_valid_r, s1_valid_nxt;
  slpw_pkg::out_word_t s1_r, s1_nxt;
  logic                s1_ring_r, s1_ring_nxt;
  logic                s1_even_r, s1_even_nxt;
  logic [7:0]          rd_byte_r;

  logic                out_valid_r;
  slpw_pkg::out_word_t out_r;
  slpw_pkg::out_word_t formed;

  logic out_take, adv, issue, mem_we, mem_re, fin_data, fin_bc;

  assign out_take = !out_valid_r || out_pop;
  assign adv      = !s1_valid_r || out_take;
  assign fin_data = (cnt_r == CNT_W'(COLUMNS_PER_BOARD - 1));
  assign fin_bc   = (cnt_r == CNT_W'(BOARD_COUNT - 1));
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign mem_we   = q_pop && (q_cmd.kind == slpw_pkg::OP_LOAD);
  assign mem_re   = (state_r == ST_DATA) && adv;
  assign issue    = (state_r != ST_IDLE) && adv;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    board_nxt    = board_r;
    pos_nxt      = pos_r;
    data_nxt     = data_r;
    s1_valid_nxt = adv ? issue : s1_valid_r;
    s1_nxt       = s1_r;
    s1_ring_nxt  = s1_ring_r;
    s1_even_nxt  = s1_even_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          board_nxt = q_cmd.board;
          pos_nxt   = q_cmd.pos;
          data_nxt  = q_cmd.data;
          cnt_nxt   = '0;
          case (q_cmd.kind)
            slpw_pkg::OP_REFRESH: state_nxt = ST_PRE;
            slpw_pkg::OP_BCAST:   state_nxt = ST_BC;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PRE: begin
        if (adv) begin
          s1_nxt.panel_select   = board_r;
          s1_nxt.bit_count      = slpw_pkg::BITS_PREFIX;
          s1_nxt.serial_word    = slpw_pkg::PREFIX_CMD | {5'd0, start_addr};
          s1_nxt.release_select = 1'b0;
          s1_nxt.last           = 1'b0;
          s1_ring_nxt           = 1'b0;
          s1_even_nxt           = 1'b0;
          state_nxt             = ST_DATA;
        end
      end
      ST_DATA: begin
        if (adv) begin
          s1_nxt.panel_select   = board_r;
          s1_nxt.bit_count      = slpw_pkg::BITS_DATA;
          s1_nxt.serial_word    = '0;
          s1_nxt.release_select = fin_data;
          s1_nxt.last           = fin_data;
          s1_ring_nxt           = 1'b1;
          s1_even_nxt           = !pos_r[0];
          pos_nxt               = pos_r + 1'b1;
          cnt_nxt               = cnt_r + 1'b1;
          if (fin_data) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BC: begin
        if (adv) begin
          s1_nxt.panel_select   = cnt_r[1:0];
          s1_nxt.bit_count      = slpw_pkg::BITS_CMD;
          s1_nxt.serial_word    = data_r;
          s1_nxt.release_select = 1'b1;
          s1_nxt.last           = fin_bc;
          s1_ring_nxt           = 1'b0;
          s1_even_nxt           = 1'b0;
          cnt_nxt               = cnt_r + 1'b1;
          if (fin_bc) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    formed = s1_r;
    if (s1_ring_r) begin
      formed.serial_word = s1_even_r ? {4'd0, rd_byte_r >> even_shift} : {4'd0, rd_byte_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (out_take) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    board_r   <= board_nxt;
    pos_r     <= pos_nxt;
    data_r    <= data_nxt;
    s1_r      <= s1_nxt;
    s1_ring_r <= s1_ring_nxt;
    s1_even_r <= s1_even_nxt;
    if (out_take && s1_valid_r) begin
      out_r <= formed;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[q_cmd.pos] <= q_cmd.data[7:0];
    end
    if (mem_re) begin
      rd_byte_r <= ring[pos_r];
    end
  end

  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

endmodule

@@ hdl/slpw_checker.sv @@
module slpw_checker #(
  parameter int BOARD_COUNT = slpw_pkg::BOARDS_DEFAULT
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input slpw_pkg::out_word_t out_word
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("stalled result changed");

  a_prefix_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.bit_count == slpw_pkg::BITS_PREFIX) |->
    (!out_word.release_select && !out_word.last))
    else $error("prefix word closes the request");

  a_data_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.bit_count == slpw_pkg::BITS_DATA) |->
    (out_word.serial_word[11:8] == 4'd0 && out_word.release_select == out_word.last))
    else $error("data word malformed");

  a_bcast_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.bit_count == slpw_pkg::BITS_CMD) |->
    (out_word.release_select &&
     (out_word.last == (out_word.panel_select == 2'(BOARD_COUNT - 1)))))
    else $error("command word flags wrong");

endmodule

bind scrolling_led_panel_writer_top slpw_checker #(
  .BOARD_COUNT(BOARD_COUNT)
) u_slpw_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_empty(out_empty),
  .out_pop(out_pop),
  .out_word(out_word)
);

@@ verif/panel_word_checker.sv @@
module panel_word_checker #(
  parameter int COLUMNS = slpw_pkg::COLUMNS_DEFAULT,
  parameter int BOARDS  = slpw_pkg::BOARDS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  slpw_pkg::in_req_t   in_req,
  input  logic                out_empty,
  input  logic                out_pop,
  input  slpw_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data,
  output int                  errors,
  output int                  pending
);

  logic [7:0]          column_copy [slpw_pkg::RING_BYTES];
  logic [2:0]          even_shift_now;
  logic [6:0]          start_addr_now;
  slpw_pkg::out_word_t words_due [$];
  slpw_pkg::out_word_t want;
  int unsigned         ring_pos;
  logic [7:0]          col;

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      even_shift_now = 3'd2;
      start_addr_now = 7'd0;
      words_due.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (words_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: sel %0d bits %0d word %03h rel %0b last %0b",
                     out_word.panel_select, out_word.bit_count, out_word.serial_word,
                     out_word.release_select, out_word.last);
        end else begin
          want = words_due.pop_front();
          if (out_word.panel_select !== want.panel_select ||
              out_word.bit_count !== want.bit_count ||
              out_word.serial_word !== want.serial_word ||
              out_word.release_select !== want.release_select ||
              out_word.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("word differs: expected %0d/%0d/%03h/%0b/%0b got %0d/%0d/%03h/%0b/%0b",
                       want.panel_select, want.bit_count, want.serial_word,
                       want.release_select, want.last,
                       out_word.panel_select, out_word.bit_count, out_word.serial_word,
                       out_word.release_select, out_word.last);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == slpw_pkg::CFG_EVEN_SHIFT) begin
          even_shift_now = cfg_data[2:0];
        end else begin
          start_addr_now = cfg_data;
        end
      end

      if (in_push && !in_full) begin
        case (in_req.operation)
          slpw_pkg::OP_LOAD: begin
            column_copy[in_req.ring_address] = in_req.byte_value;
          end
          slpw_pkg::OP_REFRESH: begin
            if (in_req.board < BOARDS) begin
              words_due.push_back('{in_req.board, slpw_pkg::BITS_PREFIX,
                                    slpw_pkg::PREFIX_CMD | {5'b0, start_addr_now},
                                    1'b0, 1'b0});
              ring_pos = (in_req.scroll_offset + COLUMNS * in_req.board) %
                         slpw_pkg::RING_BYTES;
              for (int i = 0; i < COLUMNS; i++) begin
                col = column_copy[ring_pos];
                if (ring_pos[0] == 1'b0) col = col >> even_shift_now;
                words_due.push_back('{in_req.board, slpw_pkg::BITS_DATA, {4'b0, col},
                                      i == COLUMNS - 1, i == COLUMNS - 1});
                ring_pos = (ring_pos + 1) % slpw_pkg::RING_BYTES;
              end
            end
          end
          slpw_pkg::OP_BCAST: begin
            for (int b = 0; b < BOARDS; b++)
              words_due.push_back('{2'(b), slpw_pkg::BITS_CMD,
                                    in_req.command_code & slpw_pkg::CMD_MASK,
                                    1'b1, b == BOARDS - 1});
          end
          default: begin
          end
        endcase
      end
    end
    pending = words_due.size();
  end

endmodule

@@ verif/tb.sv @@
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE = 64;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  slpw_pkg::in_req_t   in_req = '0;
  logic                out_pop = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_index = slpw_pkg::CFG_EVEN_SHIFT;
  logic [6:0]          cfg_data = '0;
  logic                in_full;
  logic                out_empty;
  logic                cfg_ready;
  slpw_pkg::out_word_t out_word;
  logic                quiet = 1'b0;
  int unsigned         pop_left = 0;
  int                  errors;
  int                  pending;

  always #5 clk = ~clk;

  scrolling_led_panel_writer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  panel_word_checker words_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // stall the result side in bursts, never once quiet
  always @(posedge clk) begin
    if (quiet) begin
      out_pop  <= 1'b1;
      pop_left <= 0;
    end else if (pop_left != 0) begin
      pop_left <= pop_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_pop  <= 1'b0;
      pop_left <= $urandom_range(0, 17);
    end else begin
      out_pop  <= 1'b1;
      pop_left <= $urandom_range(0, 29);
    end
  end

  function automatic slpw_pkg::in_req_t req(input logic [1:0] op, input logic [1:0] board,
                                            input logic [6:0] addr, input logic [7:0] val,
                                            input logic [6:0] off, input logic [11:0] cmd);
    slpw_pkg::in_req_t r;
    r.operation     = op;
    r.board         = board;
    r.ring_address  = addr;
    r.byte_value    = val;
    r.scroll_offset = off;
    r.command_code  = cmd;
    return r;
  endfunction

  // hold push high across back-to-back requests, with random gaps unless quiet
  task automatic push_req(input slpw_pkg::in_req_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_req  <= r;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain;
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [2:0] shift, input logic [6:0] addr);
    cfg_valid <= 1'b1;
    cfg_index <= slpw_pkg::CFG_EVEN_SHIFT;
    cfg_data  <= {4'b0, shift};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= slpw_pkg::CFG_START_ADDR;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    slpw_pkg::in_req_t r;
    logic [63:0]       raw;
    int                k;
    int                done;
    done = 0;
    while (done < count) begin
      raw = {$urandom, $urandom};
      r = raw[$bits(slpw_pkg::in_req_t)-1:0];
      k = $urandom_range(0, 99);
      if (k < 40) r.operation = slpw_pkg::OP_LOAD;
      else if (k < 78) r.operation = slpw_pkg::OP_REFRESH;
      else if (k < 95) r.operation = slpw_pkg::OP_BCAST;
      else r.operation = OP_UNUSED;
      push_req(r);
      if (r.operation != OP_UNUSED) done++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole ring before any refresh
    for (int a = 0; a < slpw_pkg::RING_BYTES; a++)
      push_req(req(slpw_pkg::OP_LOAD, 2'd0, a[6:0], 8'($urandom), 7'd0, 12'd0));

    push_req(req(slpw_pkg::OP_LOAD, 2'd3, 7'd0, 8'hFF, 7'd127, 12'hFFF));
    push_req(req(slpw_pkg::OP_LOAD, 2'd0, 7'd1, 8'hFF, 7'd0, 12'd0));
    push_req(req(slpw_pkg::OP_LOAD, 2'd0, 7'd127, 8'hFF, 7'd0, 12'd0));
    push_req(req(slpw_pkg::OP_LOAD, 2'd0, 7'd126, 8'h00, 7'd0, 12'd0));
    push_req(req(slpw_pkg::OP_LOAD, 2'd0, 7'd2, 8'h80, 7'd0, 12'd0));
    push_req(req(slpw_pkg::OP_LOAD, 2'd0, 7'd64, 8'h01, 7'd0, 12'd0));
    push_req(req(slpw_pkg::OP_REFRESH, 2'd0, 7'd0, 8'd0, 7'd0, 12'd0));
    push_req(req(slpw_pkg::OP_REFRESH, 2'd3, 7'd127, 8'hFF, 7'd127, 12'hFFF));
    push_req(req(slpw_pkg::OP_REFRESH, 2'd1, 7'd0, 8'd0, 7'd127, 12'd0));
    push_req(req(slpw_pkg::OP_REFRESH, 2'd0, 7'd0, 8'd0, 7'd100, 12'd0));
    push_req(req(slpw_pkg::OP_REFRESH, 2'd0, 7'd0, 8'd0, 7'd127, 12'd0));
    push_req(req(slpw_pkg::OP_REFRESH, 2'd2, 7'd0, 8'd0, 7'd0, 12'd0));
    push_req(req(slpw_pkg::OP_BCAST, 2'd0, 7'd0, 8'd0, 7'd0, 12'h000));
    push_req(req(slpw_pkg::OP_BCAST, 2'd3, 7'd127, 8'hFF, 7'd127, 12'hFFF));
    push_req(req(OP_UNUSED, 2'd1, 7'd5, 8'h5A, 7'd9, 12'h123));
    push_req(req(slpw_pkg::OP_REFRESH, 2'd1, 7'd0, 8'd0, 7'd64, 12'd0));
    drain();

    write_regs(3'd0, 7'd127);
    random_phase(4);
    drain();

    write_regs(3'd7, 7'd0);
    random_phase(4);
    drain();

    write_regs(3'($urandom), 7'($urandom));
    random_phase(4);
    drain();

    quiet <= 1'b1;
    write_regs(3'($urandom), 7'($urandom));
    random_phase(4);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("scrolling_led_panel_writer_top: match");
    end else begin
      $display("scrolling_led_panel_writer_top: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("scrolling_led_panel_writer_top: mismatch");
    $finish;
  end

endmodule
